/* rtl/core/prefix_rolling_hash_substring_query_macros.svh */
// Assertion macros shared by the rolling hash block.
// Included by the top level only; no dependencies.
`ifndef PREFIX_ROLLING_HASH_SUBSTRING_QUERY_MACROS_SVH
`define PREFIX_ROLLING_HASH_SUBSTRING_QUERY_MACROS_SVH
`define PRH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/core/prh_pkg.sv */
// Shared types and constants for the rolling hash block.
// No dependencies.
package prh_pkg;
  localparam int MAX_LEN = 4096;
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = AW + 1;
  localparam int HW = 30;
  // A product of two stored values plus the character offset term fits here.
  localparam int PW = 2 * HW + 2;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic REG_BASE    = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_RD, ST_MUL, ST_RED, ST_WAIT, ST_MUL2, ST_RED2,
    ST_WAIT2, ST_WR, ST_OUT
  } state_t;

  typedef struct packed {
    logic       latch;     // capture item and config
    logic       prep;      // form the character offset term
    logic       rd;        // issue memory reads
    logic       mul;       // load the reduction operand
    logic       sel2;      // second pass operand
    logic       red;       // start reduction
    logic       cap1;      // keep first pass remainder
    logic       cap2;      // keep second pass remainder
    logic       wr;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bad;
    logic       red_done;
  } stat_t;
endpackage

/* rtl/core/prefix_rolling_hash_substring_query.sv */
// Channel  | ports                                  | handshake
// input    | in_mode in_char_byte in_left_pos ...   | start && !busy
// result   | out_hash_value out_string_length ...   | out_valid, one cycle
// config   | cfg_we cfg_index cfg_data              | cfg_we
// An append strobes its result after two 62-step serial reductions by the modulus and
// a store write, a query after the two reductions alone. Clear and rejected items skip
// them. The earliest next acceptance is in the cycle after the result strobe.
// Reset is synchronous, active low; the stores are not cleared.
// The result strobe cannot be stalled.
module prefix_rolling_hash_substring_query (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_byte,
  input  logic [12:0] in_left_pos,
  input  logic [12:0] in_right_pos,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [29:0] cfg_data,
  output logic        out_valid,
  output logic [29:0] out_hash_value,
  output logic [12:0] out_string_length,
  output logic        out_error
);
  import prh_pkg::*;
  `include "prefix_rolling_hash_substring_query_macros.svh"
  ctrl_t ctrl;
  stat_t stat;
  prh_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .done(out_valid), .ctrl, .stat);
  prh_datapath u_dp (.clk, .rst_n, .ctrl, .stat, .in_mode, .in_char_byte,
    .in_left_pos, .in_right_pos, .cfg_we, .cfg_index, .cfg_data,
    .out_hash_value, .out_string_length, .out_error);
  `PRH_ASSERT_NEXT(a_done_idle, out_valid, !busy, "busy after result")
  `PRH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")
  `PRH_ASSERT_IMPL(a_err_zero, out_valid && out_error, out_hash_value == '0, "error with hash")
endmodule

/* rtl/core/prh_modred.sv */
// Serial reduction of a wide operand by a runtime modulus, one bit a cycle.
// Depends on prh_pkg.
module prh_modred (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [prh_pkg::PW-1:0] prod,
  input  logic [prh_pkg::HW-1:0] modulus,
  output logic                   done,
  output logic [prh_pkg::HW-1:0] rem
);
  import prh_pkg::*;
  logic [PW-1:0] sh_r, sh_nxt;
  logic [HW-1:0] acc_r, acc_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [HW:0]   t;

  // The partial remainder stays below the modulus, so one compare-subtract per bit suffices.
  assign t = {acc_r, sh_r[PW-1]};
  always_comb begin
    sh_nxt = sh_r; acc_nxt = acc_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      sh_nxt = prod; acc_nxt = '0; cnt_nxt = 6'(PW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt = {sh_r[PW-2:0], 1'b0};
      acc_nxt = (t >= {1'b0, modulus}) ? HW'(t - {1'b0, modulus}) : HW'(t);
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt; acc_r <= acc_nxt;
  end
  assign done = busy_r && (cnt_r == 6'd1);
  assign rem = acc_nxt;
endmodule

/* rtl/core/prh_datapath.sv */
// Datapath: configuration, item registers, hash stores, multiplier and reduction.
// Depends on prh_pkg and prh_modred.
module prh_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  prh_pkg::ctrl_t      ctrl,
  output prh_pkg::stat_t      stat,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_char_byte,
  input  logic [12:0]         in_left_pos,
  input  logic [12:0]         in_right_pos,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [29:0]         cfg_data,
  output logic [29:0]         out_hash_value,
  output logic [12:0]         out_string_length,
  output logic                out_error
);
  import prh_pkg::*;
  logic [HW-1:0]   prefix_mem [MAX_LEN];
  logic [HW-1:0]   power_mem  [MAX_LEN];
  logic [HW-1:0]   base_cfg_r, mod_cfg_r, m_eff;
  logic [HW-1:0]   m_r, b_r, rd_h_r, rd_p_r, rd_r_r, acc_r, res2_r;
  logic [1:0]      mode_r;
  logic [7:0]      ch_r;
  logic [LW-1:0]   len_r, l_r, r_r;
  logic            bad_r;
  logic [PW-1:0]   prod_r, off_r, red_in;
  logic [2*HW-1:0] mul_res;
  logic [HW-1:0]   op_a, op_b, rem;
  logic [AW-1:0]   ia, ip, ir;
  logic            h_zero, p_one, rdone;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r <= HW'(31); mod_cfg_r <= HW'(1000000007);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:    base_cfg_r <= cfg_data;
        REG_MODULUS: mod_cfg_r <= cfg_data;
      endcase
    end
  end
  assign m_eff = (mod_cfg_r < HW'(2)) ? HW'(2) : mod_cfg_r;

  prh_modred u_red (.clk, .rst_n, .start(ctrl.red), .prod(red_in), .modulus(m_r),
    .done(rdone), .rem);

  // Entry k of a store sits at address k-1; position zero is implicit.
  assign ia = (mode_r == MODE_QUERY) ? AW'(l_r - LW'(2)) : AW'(len_r - LW'(1));
  assign ip = (mode_r == MODE_QUERY) ? AW'(r_r - l_r) : AW'(len_r - LW'(1));
  assign ir = AW'(r_r - LW'(1));
  assign h_zero = (mode_r == MODE_QUERY) ? (l_r == LW'(1)) : (len_r == '0);
  assign p_one = (len_r == '0);

  // Operands need no prior reduction: the remainder of the product is the same.
  assign op_a = ctrl.sel2 ? (p_one ? HW'(1) : rd_p_r) : (h_zero ? '0 : rd_h_r);
  assign op_b = (mode_r == MODE_APPEND) ? b_r : rd_p_r;
  assign mul_res = {{HW{1'b0}}, op_a} * {{HW{1'b0}}, op_b};
  assign red_in = prod_r + off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; mode_r <= MODE_CLEAR; bad_r <= 1'b0;
    end else begin
      if (ctrl.latch) begin
        mode_r <= in_mode;
        unique case (in_mode)
          MODE_APPEND: bad_r <= (len_r >= LW'(MAX_LEN));
          MODE_QUERY:  bad_r <= (in_left_pos == '0) || (in_left_pos > in_right_pos)
                                || (in_right_pos > len_r);
          MODE_CLEAR:  bad_r <= 1'b0;
          default:     bad_r <= 1'b1;
        endcase
      end
      if (ctrl.prep && mode_r == MODE_CLEAR) len_r <= '0;
      if (ctrl.wr) len_r <= len_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      m_r <= m_eff;
      b_r <= base_cfg_r;
      ch_r <= in_char_byte;
      l_r <= in_left_pos;
      r_r <= in_right_pos;
    end
    // Adding 96 times the modulus keeps a negative character offset non-negative.
    if (ctrl.prep) begin
      off_r <= (mode_r == MODE_APPEND) ?
               (PW'(m_r) << 6) + (PW'(m_r) << 5) + PW'(ch_r) - PW'(96) : '0;
    end else if (ctrl.mul && ctrl.sel2) begin
      off_r <= '0;
    end
    if (ctrl.rd) begin
      rd_h_r <= prefix_mem[ia];
      rd_p_r <= power_mem[ip];
    end
    if (ctrl.mul && !ctrl.sel2) rd_r_r <= prefix_mem[ir];
    if (ctrl.mul) begin
      prod_r <= (ctrl.sel2 && mode_r == MODE_QUERY) ?
                PW'(rd_r_r) + PW'(m_r) - PW'(acc_r) : PW'(mul_res);
    end
    if (ctrl.cap1 && rdone) acc_r <= rem;
    if (ctrl.cap2 && rdone) res2_r <= rem;
    if (ctrl.wr) begin
      prefix_mem[len_r[AW-1:0]] <= acc_r;
      power_mem[len_r[AW-1:0]] <= res2_r;
    end
  end

  assign stat.mode = mode_r;
  assign stat.bad = bad_r;
  assign stat.red_done = rdone;
  assign out_hash_value = bad_r ? '0 :
                          (mode_r == MODE_APPEND) ? acc_r :
                          (mode_r == MODE_QUERY) ? res2_r : '0;
  assign out_string_length = len_r;
  assign out_error = bad_r;
endmodule

/* rtl/core/prh_ctrl.sv */
// Controller state machine sequencing reads, multiplies and reductions.
// Depends on prh_pkg.
module prh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output prh_pkg::ctrl_t ctrl,
  input  prh_pkg::stat_t stat
);
  import prh_pkg::*;
  state_t state_r, state_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = (stat.bad || stat.mode == MODE_CLEAR) ? ST_OUT : ST_RD;
      ST_RD:    state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_RED;
      ST_RED:   state_nxt = ST_WAIT;
      ST_WAIT:  if (stat.red_done) state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_RED2;
      ST_RED2:  state_nxt = ST_WAIT2;
      ST_WAIT2: if (stat.red_done) state_nxt = (stat.mode == MODE_APPEND) ? ST_WR : ST_OUT;
      ST_WR:    state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE:  ctrl.latch = start;
      ST_PREP:  ctrl.prep = 1'b1;
      ST_RD:    ctrl.rd = 1'b1;
      ST_MUL:   ctrl.mul = 1'b1;
      ST_RED:   ctrl.red = 1'b1;
      ST_WAIT:  ctrl.cap1 = 1'b1;
      ST_MUL2:  begin ctrl.mul = 1'b1; ctrl.sel2 = 1'b1; end
      ST_RED2:  ctrl.red = 1'b1;
      ST_WAIT2: ctrl.cap2 = 1'b1;
      ST_WR:    ctrl.wr = 1'b1;
      ST_OUT:   ctrl = '0;
      default:  ctrl = '0;
    endcase
  end
  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_OUT);
endmodule

/* tb/prefix_rolling_hash_substring_query_tb.sv */
// Self-checking testbench for the polynomial rolling hash block with substring queries.
// Depends on prh_pkg and on the block itself; it has its own hash predictor and checks every result.
module prefix_rolling_hash_substring_query_tb;
  import prh_pkg::*;

  localparam int         STALL_LIMIT = 5000;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  mode;
    logic [7:0]  ch;
    logic [12:0] lpos;
    logic [12:0] rpos;
    logic        idx;
    logic [29:0] data;
  } op_t;

  typedef struct {
    logic [29:0] hash;
    logic [12:0] len;
    logic        err;
  } hash_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_char_byte = '0;
  logic [12:0] in_left_pos = '0;
  logic [12:0] in_right_pos = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [29:0] cfg_data = '0;
  logic        out_valid;
  logic [29:0] out_hash_value;
  logic [12:0] out_string_length;
  logic        out_error;

  op_t          pending_ops[$];
  hash_result_t expected_hashes[$];
  bit           failed = 1'b0;
  int unsigned  cycle_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_cycles = 0;
  int           gen_len = 0;

  // Predictor state: entries as written under the modulus of their time, reduced on read like the block.
  logic [29:0]  pred_hash[MAX_LEN];
  logic [29:0]  pred_pow[MAX_LEN];
  int           pred_len = 0;
  logic [29:0]  pred_base = 30'd31;
  logic [29:0]  pred_mod = 30'd1000000007;

  prefix_rolling_hash_substring_query dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned prefix_at(int k, longint unsigned m);
    return (k == 0) ? 0 : longint'(pred_hash[k-1]) % m;
  endfunction

  function automatic longint unsigned power_at(int k, longint unsigned m);
    return (k == 0) ? 1 % m : longint'(pred_pow[k-1]) % m;
  endfunction

  function automatic hash_result_t predict_hash(op_t it);
    hash_result_t res;
    longint unsigned m, b, v, h, p, lft;
    m = (pred_mod < 2) ? 2 : longint'(pred_mod);
    b = longint'(pred_base) % m;
    res.hash = '0;
    res.err = 1'b0;
    case (it.mode)
      MODE_APPEND: begin
        if (pred_len >= MAX_LEN) begin
          res.err = 1'b1;
        end else begin
          if (it.ch >= 96) v = longint'(it.ch - 96) % m;
          else v = (m - longint'(96 - it.ch) % m) % m;
          h = (prefix_at(pred_len, m) * b + v) % m;
          p = (power_at(pred_len, m) * b) % m;
          pred_hash[pred_len] = h[29:0];
          pred_pow[pred_len] = p[29:0];
          pred_len++;
          res.hash = h[29:0];
        end
      end
      MODE_QUERY: begin
        if (it.lpos < 1 || it.lpos > it.rpos || it.rpos > pred_len) begin
          res.err = 1'b1;
        end else begin
          lft = (prefix_at(it.lpos - 1, m) * power_at(it.rpos - it.lpos + 1, m)) % m;
          h = (prefix_at(it.rpos, m) + m - lft) % m;
          res.hash = h[29:0];
        end
      end
      MODE_CLEAR: pred_len = 0;
      default: res.err = 1'b1;
    endcase
    res.len = pred_len[12:0];
    return res;
  endfunction

  // Driver: one nonblocking assignment per signal per edge.
  always @(posedge clk) begin
    bit   accepted, nxt_start, nxt_we, may_go;
    op_t  op;
    accepted = rst_n && start && !busy;
    nxt_start = start && !accepted;
    nxt_we = 1'b0;
    cycle_count++;
    if (accepted) expected_hashes.insert(expected_hashes.size(),
                                         predict_hash('{1'b0, in_mode, in_char_byte,
                                                        in_left_pos, in_right_pos,
                                                        1'b0, '0}));
    quiet_cycles = (expected_hashes.size() == 0 && !start) ? quiet_cycles + 1 : 0;
    // A long calm stretch with no gaps on the input side.
    may_go = (cycle_count > 40000 && cycle_count < 120000) || ($urandom_range(99) >= 30);
    if (rst_n && !nxt_start && pending_ops.size() > 0) begin
      op = pending_ops[0];
      if (op.is_cfg) begin
        if (quiet_cycles > 4 && !busy) begin
          void'(pending_ops.pop_front());
          nxt_we = 1'b1;
          cfg_index <= op.idx;
          cfg_data <= op.data;
          if (op.idx == REG_BASE) pred_base = op.data;
          else pred_mod = op.data;
        end
      end else if (may_go) begin
        void'(pending_ops.pop_front());
        nxt_start = 1'b1;
        in_mode <= op.mode;
        in_char_byte <= op.ch;
        in_left_pos <= op.lpos;
        in_right_pos <= op.rpos;
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
    stall_cycles = (accepted || nxt_we || out_valid) ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Monitor: results cannot be held off, so every strobe is a transaction.
  always @(posedge clk) begin
    hash_result_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_hashes.size() == 0) begin
        $error("unexpected result: hash_value %0d", out_hash_value);
        failed = 1'b1;
      end else begin
        exp_res = expected_hashes.pop_front();
        if (out_hash_value !== exp_res.hash) begin
          $error("hash_value expected %0d actual %0d", exp_res.hash, out_hash_value);
          failed = 1'b1;
        end
        if (out_string_length !== exp_res.len) begin
          $error("string_length expected %0d actual %0d", exp_res.len, out_string_length);
          failed = 1'b1;
        end
        if (out_error !== exp_res.err) begin
          $error("error expected %0d actual %0d", exp_res.err, out_error);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic add_item(logic [1:0] mode, logic [7:0] ch, logic [12:0] lpos,
                          logic [12:0] rpos);
    pending_ops.insert(pending_ops.size(), '{1'b0, mode, ch, lpos, rpos, 1'b0, '0});
    if (mode == MODE_APPEND && gen_len < MAX_LEN) gen_len++;
    else if (mode == MODE_CLEAR) gen_len = 0;
  endtask

  task automatic add_cfg(logic idx, logic [29:0] data);
    pending_ops.insert(pending_ops.size(), '{1'b1, '0, '0, '0, '0, idx, data});
  endtask

  task automatic add_random_items(int count);
    int sel, l, r;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 55 && gen_len < 60) begin
        add_item(MODE_APPEND, 8'($urandom_range(255)), 13'($urandom), 13'($urandom));
      end else if (sel < 90) begin
        if (gen_len > 0 && $urandom_range(99) < 80) begin
          r = $urandom_range(gen_len, 1);
          l = $urandom_range(r, 1);
          add_item(MODE_QUERY, 8'($urandom), 13'(l), 13'(r));
        end else begin
          add_item(MODE_QUERY, 8'($urandom), 13'($urandom), 13'($urandom));
        end
      end else if (sel < 96) begin
        add_item(MODE_CLEAR, 8'($urandom), 13'($urandom), 13'($urandom));
      end else if (sel < 98) begin
        add_item(MODE_UNUSED, 8'($urandom), 13'($urandom), 13'($urandom));
      end else begin
        add_item(MODE_APPEND, 8'($urandom_range(255)), 13'($urandom), 13'($urandom));
      end
    end
  endtask

  initial begin
    logic [29:0] bases[8], mods[8];
    bases = '{30'd31, 30'd1, 30'd1073741822, 30'h3FFFFFFF, 30'd907, 30'd5, 30'd0, 30'd257};
    mods  = '{30'd1000000007, 30'd2, 30'd1073741823, 30'd0, 30'd1000000021, 30'd1,
              30'd97, 30'd1000000007};
    // Directed part under the reset configuration.
    add_item(MODE_QUERY, 8'd0, 13'd1, 13'd1);
    add_item(MODE_APPEND, 8'd0, 13'd0, 13'd0);
    add_item(MODE_APPEND, 8'd255, 13'h1FFF, 13'h1FFF);
    add_item(MODE_APPEND, 8'd96, 13'd0, 13'd0);
    add_item(MODE_APPEND, 8'd97, 13'd0, 13'd0);
    add_item(MODE_APPEND, 8'd95, 13'd0, 13'd0);
    add_item(MODE_QUERY, 8'd0, 13'd1, 13'd5);
    add_item(MODE_QUERY, 8'd0, 13'd2, 13'd4);
    add_item(MODE_QUERY, 8'd0, 13'd5, 13'd5);
    add_item(MODE_QUERY, 8'd0, 13'd0, 13'd3);
    add_item(MODE_QUERY, 8'd0, 13'd4, 13'd3);
    add_item(MODE_QUERY, 8'd0, 13'd1, 13'd6);
    add_item(MODE_QUERY, 8'd0, 13'h1FFF, 13'h1FFF);
    add_item(MODE_UNUSED, 8'd0, 13'd1, 13'd1);
    add_item(MODE_CLEAR, 8'd0, 13'd0, 13'd0);
    add_item(MODE_QUERY, 8'd0, 13'd1, 13'd1);
    add_item(MODE_APPEND, 8'd122, 13'd0, 13'd0);
    for (int s = 0; s < 8; s++) begin
      add_cfg(REG_BASE, bases[s]);
      add_cfg(REG_MODULUS, mods[s]);
      // Now and then the string is kept across a change of modulus.
      if ($urandom_range(3) != 0) begin
        add_item(MODE_CLEAR, 8'($urandom), 13'($urandom), 13'($urandom));
      end
      add_random_items(140);
    end
    add_cfg(REG_BASE, 30'($urandom));
    add_cfg(REG_MODULUS, 30'($urandom_range(1073741823, 2)));
    add_item(MODE_CLEAR, 8'd0, 13'd0, 13'd0);
    add_random_items(150);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !start && expected_hashes.size() == 0);
    repeat (200) @(posedge clk);
    if (!failed && expected_hashes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/prh_pkg.sv
rtl/core/prh_modred.sv
rtl/core/prh_datapath.sv
rtl/core/prh_ctrl.sv
rtl/core/prefix_rolling_hash_substring_query.sv
tb/prefix_rolling_hash_substring_query_tb.sv
